FILE: rtl/generational_handle_table_unit_macros.svh
// Assertion macros for the handle table unit.
// Both expect clk and arst_n in the scope that uses them.
`ifndef GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_TABLE_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define GHT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/ght_pkg.sv
`timescale 1ns / 1ps

package ght_pkg;

	localparam int HANDLES_DEF  = 64;
	localparam int GEN_BITS_DEF = 16;

	localparam logic [1:0] OP_CREATE = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_STALE = 2'd2;

	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam step_t STEP_C_PICK  = 3'd0;
	localparam step_t STEP_C_LINK  = 3'd1;
	localparam step_t STEP_H_READ  = 3'd2;
	localparam step_t STEP_H_OWNER = 3'd3;
	localparam step_t STEP_H_MOVE  = 3'd4;
	localparam step_t STEP_H_FREE  = 3'd5;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_END,
		JMP_END_IF_FULL,
		JMP_END_IF_KEEP
	} jmp_t;

	typedef struct packed {
		logic rd_slot;
		logic rd_owner;
		logic pick;
		logic link;
		logic move;
		logic free;
		jmp_t jmp;
	} cw_t;

	function automatic cw_t ght_rom(input step_t step);
		cw_t cw;
		cw = '{rd_slot: 1'b0, rd_owner: 1'b0, pick: 1'b0, link: 1'b0,
			move: 1'b0, free: 1'b0, jmp: JMP_END};
		case (step)
			STEP_C_PICK: begin
				cw.pick = 1'b1;
				cw.jmp  = JMP_END_IF_FULL;
			end
			STEP_C_LINK: begin
				cw.link = 1'b1;
				cw.jmp  = JMP_END;
			end
			STEP_H_READ: begin
				cw.rd_slot = 1'b1;
				cw.jmp     = JMP_NEXT;
			end
			STEP_H_OWNER: begin
				cw.rd_owner = 1'b1;
				cw.jmp      = JMP_NEXT;
			end
			STEP_H_MOVE: begin
				cw.move = 1'b1;
				cw.jmp  = JMP_END_IF_KEEP;
			end
			STEP_H_FREE: begin
				cw.free = 1'b1;
				cw.jmp  = JMP_END;
			end
			default: begin
				cw.jmp = JMP_END;
			end
		endcase
		return cw;
	endfunction

endpackage

FILE: rtl/generational_handle_table_unit.sv
`timescale 1ns / 1ps
// Generational handle table.
// Command channel: a word (operation, handle_slot, handle_generation) is taken at a
// rising edge with start high and busy low. operation selects create, delete or
// lookup; an unused code acts as lookup.
// Result channel: done is high for one cycle with status, out_slot, out_generation,
// dense_slot, moved_from and live_count. The receiver has no back pressure: each
// result must be taken in the cycle it is shown.
// Steps after the accepting edge: create runs C_PICK, C_LINK, or only C_PICK on a
// full table; lookup or a rejected handle runs H_READ, H_OWNER, H_MOVE; delete adds
// H_FREE. busy drops in the last step, so the next word may be taken at the edge that
// registers the result, never while a word is in progress. The steps are set by the
// step program in the control store and the registered read ports of the three
// handle memories: the handle check needs the slot read before the reverse-map read.
// Reset clears the counts and the free list and goes idle at once; memory contents
// are not cleared, no entry is read before it is written.
module generational_handle_table_unit
	import ght_pkg::*;
#(
	parameter int HANDLES  = HANDLES_DEF,
	parameter int GEN_BITS = GEN_BITS_DEF,
	localparam int SW = $clog2(HANDLES),
	localparam int CW = $clog2(HANDLES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          operation,
	input  logic [SW-1:0]       handle_slot,
	input  logic [GEN_BITS-1:0] handle_generation,
	output logic                done,
	output logic [1:0]          status,
	output logic [SW-1:0]       out_slot,
	output logic [GEN_BITS-1:0] out_generation,
	output logic [SW-1:0]       dense_slot,
	output logic [SW-1:0]       moved_from,
	output logic [CW-1:0]       live_count
);

	`include "generational_handle_table_unit_macros.svh"

	logic [SW-1:0]       slot_link_mem   [HANDLES];
	logic [GEN_BITS-1:0] slot_gen_mem    [HANDLES];
	logic [SW-1:0]       dense_owner_mem [HANDLES];

	logic                busy_q;
	step_t               step_q;
	logic [CW-1:0]       free_head_q;
	logic [CW-1:0]       used_q;
	logic [CW-1:0]       alloc_q;
	logic                reuse_q;
	logic                fl_one_q;
	logic                in_range_q;
	logic                ok1_q;
	logic                del_q;

	logic [SW-1:0]       s_q;
	logic [GEN_BITS-1:0] g_q;
	logic [SW-1:0]       slot_q;
	logic [GEN_BITS-1:0] gen_rd_q;
	logic [SW-1:0]       link_rd_q;
	logic [SW-1:0]       own_rd_q;
	logic [SW-1:0]       last_own_q;
	logic [SW-1:0]       last_q;

	logic                done_q;
	logic [1:0]          status_q;
	logic [SW-1:0]       out_slot_q;
	logic [GEN_BITS-1:0] out_gen_q;
	logic [SW-1:0]       dense_q;
	logic [SW-1:0]       moved_q;
	logic [CW-1:0]       live_q;

	cw_t                 cw;
	logic                accept;
	logic                end_now;
	logic                full;
	logic                reuse;
	logic                in_range;
	logic                ok1;
	logic                live;
	logic                keep;
	logic                fresh;
	logic                slot_rd_en;
	logic [SW-1:0]       slot_rd_addr;
	logic                owner_rd_en;
	logic [SW-1:0]       last_idx;
	logic                link_we;
	logic [SW-1:0]       link_wa;
	logic [SW-1:0]       link_wd;
	logic                gen_we;
	logic [SW-1:0]       gen_wa;
	logic [GEN_BITS-1:0] gen_wd;
	logic                owner_we;
	logic [SW-1:0]       owner_wa;
	logic [SW-1:0]       owner_wd;

	logic [1:0]          res_status;
	logic [SW-1:0]       res_slot;
	logic [GEN_BITS-1:0] res_gen;
	logic [SW-1:0]       res_dense;
	logic [SW-1:0]       res_moved;
	logic [CW-1:0]       res_live;

	always_comb begin
		cw       = ght_rom(step_q);
		full     = used_q == CW'(HANDLES);
		reuse    = (alloc_q > used_q) && (free_head_q < CW'(HANDLES));
		fresh    = cw.pick && !full && !reuse;
		in_range = CW'(s_q) < alloc_q;
		ok1      = in_range_q && (gen_rd_q == g_q) && (CW'(link_rd_q) < used_q);
		live     = ok1_q && (own_rd_q == s_q);
		keep     = !(live && del_q);
		last_idx = SW'(used_q - CW'(1));
		case (cw.jmp)
			JMP_NEXT:        end_now = 1'b0;
			JMP_END:         end_now = busy_q;
			JMP_END_IF_FULL: end_now = busy_q && full;
			JMP_END_IF_KEEP: end_now = busy_q && keep;
			default:         end_now = busy_q;
		endcase
		busy   = busy_q && !end_now;
		accept = start && !busy;
	end

	always_comb begin
		slot_rd_addr = cw.pick ? free_head_q[SW-1:0] : s_q;
		slot_rd_en   = busy_q && ((cw.pick && !full && reuse) || (cw.rd_slot && in_range));
		owner_rd_en  = busy_q && cw.rd_owner && ok1;

		link_we = busy_q && (cw.link || (cw.move && !keep) || cw.free);
		if (cw.link) begin
			link_wa = slot_q;
			link_wd = SW'(used_q);
		end else if (cw.move) begin
			link_wa = last_own_q;
			link_wd = link_rd_q;
		end else begin
			link_wa = s_q;
			link_wd = (free_head_q < CW'(HANDLES)) ? free_head_q[SW-1:0] : '0;
		end

		gen_we = busy_q && (fresh || cw.free);
		gen_wa = cw.pick ? SW'(alloc_q) : s_q;
		gen_wd = cw.pick ? GEN_BITS'(1) : GEN_BITS'(gen_rd_q + GEN_BITS'(1));

		owner_we = busy_q && (cw.link || (cw.move && !keep));
		owner_wa = cw.link ? SW'(used_q) : link_rd_q;
		owner_wd = cw.link ? slot_q : last_own_q;
	end

	always_comb begin
		res_status = STS_OK;
		res_slot   = s_q;
		res_gen    = g_q;
		res_dense  = '0;
		res_moved  = '0;
		res_live   = used_q;
		if (cw.pick) begin
			res_status = STS_FULL;
			res_slot   = '0;
			res_gen    = '0;
		end else if (cw.link) begin
			res_slot  = slot_q;
			res_gen   = gen_rd_q;
			res_dense = SW'(used_q);
			res_live  = CW'(used_q + CW'(1));
		end else if (cw.move) begin
			if (!live) begin
				res_status = STS_STALE;
			end else begin
				res_dense = link_rd_q;
			end
		end else if (cw.free) begin
			res_dense = link_rd_q;
			res_moved = last_q;
			res_live  = CW'(used_q - CW'(1));
		end
	end

	// Memories: one write port each, registered reads.
	always_ff @(posedge clk) begin
		if (link_we) begin
			slot_link_mem[link_wa] <= link_wd;
		end
		if (gen_we) begin
			slot_gen_mem[gen_wa] <= gen_wd;
		end
		if (owner_we) begin
			dense_owner_mem[owner_wa] <= owner_wd;
		end
		if (slot_rd_en) begin
			gen_rd_q  <= slot_gen_mem[slot_rd_addr];
			link_rd_q <= slot_link_mem[slot_rd_addr];
		end else if (busy_q && fresh) begin
			gen_rd_q <= GEN_BITS'(1);
		end
		if (owner_rd_en) begin
			own_rd_q   <= dense_owner_mem[link_rd_q];
			last_own_q <= dense_owner_mem[last_idx];
		end
	end

	// Datapath words.
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q <= handle_slot;
			g_q <= handle_generation;
		end
		if (busy_q && cw.pick) begin
			slot_q   <= reuse ? free_head_q[SW-1:0] : SW'(alloc_q);
			fl_one_q <= CW'(alloc_q - used_q) == CW'(1);
		end
		if (busy_q && cw.rd_owner) begin
			last_q <= last_idx;
		end
		if (end_now) begin
			status_q   <= res_status;
			out_slot_q <= res_slot;
			out_gen_q  <= res_gen;
			dense_q    <= res_dense;
			moved_q    <= res_moved;
			live_q     <= res_live;
		end
	end

	// Sequencer and table counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= STEP_C_PICK;
			del_q       <= 1'b0;
			reuse_q     <= 1'b0;
			in_range_q  <= 1'b0;
			ok1_q       <= 1'b0;
			free_head_q <= CW'(HANDLES);
			used_q      <= '0;
			alloc_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= end_now;
			if (accept) begin
				busy_q <= 1'b1;
				del_q  <= operation == OP_DELETE;
				step_q <= (operation == OP_CREATE) ? STEP_C_PICK : STEP_H_READ;
			end else if (end_now) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				step_q <= step_t'(step_q + step_t'(1));
			end
			if (busy_q) begin
				if (cw.pick && !full) begin
					reuse_q <= reuse;
					if (!reuse) begin
						alloc_q <= CW'(alloc_q + CW'(1));
					end
				end
				if (cw.link) begin
					if (reuse_q) begin
						free_head_q <= fl_one_q ? CW'(HANDLES) : CW'(link_rd_q);
					end
					used_q <= CW'(used_q + CW'(1));
				end
				if (cw.rd_slot) begin
					in_range_q <= in_range;
				end
				if (cw.rd_owner) begin
					ok1_q <= ok1;
				end
				if (cw.free) begin
					free_head_q <= CW'(s_q);
					used_q      <= CW'(used_q - CW'(1));
				end
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign out_slot       = out_slot_q;
	assign out_generation = out_gen_q;
	assign dense_slot     = dense_q;
	assign moved_from     = moved_q;
	assign live_count     = live_q;

	`GHT_ASSERT_NOW(a_counts_ordered, 1'b1, (used_q <= alloc_q) && (alloc_q <= CW'(HANDLES)), "live count above allocated count")
	`GHT_ASSERT_NOW(a_free_list_head, (alloc_q > used_q) && !(busy_q && cw.link), free_head_q < CW'(HANDLES), "free list empty while handles are free")
	`GHT_ASSERT_NOW(a_result_count, done, live_count == used_q, "reported live count differs from table")
	`GHT_ASSERT_NEXT(a_accept_runs, accept, busy_q, "accepted word not in progress")

endmodule

FILE: tb/sv/generational_handle_table_unit_tb.sv
`timescale 1ns / 1ps

module generational_handle_table_unit_tb;
	import ght_pkg::*;

	localparam int HANDLES     = 64;
	localparam int SW          = 6;
	localparam int GW          = 16;
	localparam int CW          = 7;
	localparam int STALL_LIMIT = 500;
	localparam int PRINT_LIMIT = 40;
	localparam int CHURN_PAIRS = 16;
	localparam int DIR_N       = 20;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]    status;
		logic [SW-1:0] slot;
		logic [GW-1:0] gen;
		logic [SW-1:0] dense;
		logic [SW-1:0] moved;
		logic [CW-1:0] live;
	} table_result_t;

	typedef struct packed {
		logic [1:0]    op;
		logic [SW-1:0] slot;
		logic [GW-1:0] gen;
		logic          typed;
		table_result_t want;
	} table_word_t;

	localparam table_result_t NO_RESULT = '0;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic [1:0]    operation = OP_CREATE;
	logic [SW-1:0] handle_slot = '0;
	logic [GW-1:0] handle_generation = '0;
	logic          busy;
	logic          done;
	logic [1:0]    status;
	logic [SW-1:0] out_slot;
	logic [GW-1:0] out_generation;
	logic [SW-1:0] dense_slot;
	logic [SW-1:0] moved_from;
	logic [CW-1:0] live_count;

	// handle table image kept alongside the block
	logic [SW-1:0] hs_link  [HANDLES];
	logic [GW-1:0] hs_gen   [HANDLES];
	logic [SW-1:0] dn_owner [HANDLES];
	logic [CW-1:0] fl_head;
	logic [CW-1:0] live_n;
	logic [CW-1:0] alloc_n;

	table_result_t pending_results [$];
	table_result_t last_pred;
	int            fail_count = 0;
	int            n_words = 0;
	int            n_results = 0;
	int            stall_cycles = 0;

	table_word_t directed_words [DIR_N] = '{
		'{OP_LOOKUP, 6'd0, 16'd0, 1'b1, '{STS_STALE, 6'd0, 16'd0, 6'd0, 6'd0, 7'd0}},
		'{OP_DELETE, 6'd63, 16'd65535, 1'b1,
			'{STS_STALE, 6'd63, 16'd65535, 6'd0, 6'd0, 7'd0}},
		'{OP_CREATE, 6'd63, 16'd65535, 1'b1, '{STS_OK, 6'd0, 16'd1, 6'd0, 6'd0, 7'd1}},
		'{OP_CREATE, 6'd0, 16'd0, 1'b0, NO_RESULT},
		'{OP_CREATE, 6'd21, 16'd4660, 1'b0, NO_RESULT},
		'{OP_LOOKUP, 6'd1, 16'd1, 1'b0, NO_RESULT},
		'{OP_LOOKUP, 6'd1, 16'd2, 1'b1, '{STS_STALE, 6'd1, 16'd2, 6'd0, 6'd0, 7'd3}},
		'{OP_LOOKUP, 6'd5, 16'd1, 1'b1, '{STS_STALE, 6'd5, 16'd1, 6'd0, 6'd0, 7'd3}},
		'{OP_UNUSED, 6'd2, 16'd1, 1'b0, NO_RESULT},
		'{OP_DELETE, 6'd0, 16'd1, 1'b0, NO_RESULT},
		'{OP_LOOKUP, 6'd0, 16'd2, 1'b1, '{STS_STALE, 6'd0, 16'd2, 6'd0, 6'd0, 7'd2}},
		'{OP_LOOKUP, 6'd2, 16'd1, 1'b0, NO_RESULT},
		'{OP_DELETE, 6'd1, 16'd1, 1'b0, NO_RESULT},
		'{OP_CREATE, 6'd42, 16'd43690, 1'b0, NO_RESULT},
		'{OP_CREATE, 6'd63, 16'd21845, 1'b0, NO_RESULT},
		'{OP_CREATE, 6'd0, 16'd65535, 1'b0, NO_RESULT},
		'{OP_DELETE, 6'd3, 16'd1, 1'b0, NO_RESULT},
		'{OP_DELETE, 6'd2, 16'd65535, 1'b1,
			'{STS_STALE, 6'd2, 16'd65535, 6'd0, 6'd0, 7'd3}},
		'{OP_UNUSED, 6'd63, 16'd0, 1'b1, '{STS_STALE, 6'd63, 16'd0, 6'd0, 6'd0, 7'd3}},
		'{OP_DELETE, 6'd0, 16'd1, 1'b1, '{STS_STALE, 6'd0, 16'd1, 6'd0, 6'd0, 7'd3}}
	};

	generational_handle_table_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.handle_slot(handle_slot),
		.handle_generation(handle_generation),
		.done(done),
		.status(status),
		.out_slot(out_slot),
		.out_generation(out_generation),
		.dense_slot(dense_slot),
		.moved_from(moved_from),
		.live_count(live_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic slot_is_live(logic [SW-1:0] s, logic [GW-1:0] g);
		if ({1'b0, s} >= alloc_n)
			return 1'b0;
		if (hs_gen[s] != g)
			return 1'b0;
		if ({1'b0, hs_link[s]} >= live_n)
			return 1'b0;
		return dn_owner[hs_link[s]] == s;
	endfunction

	function automatic table_result_t predict_table_op(logic [1:0] op, logic [SW-1:0] s,
			logic [GW-1:0] g);
		table_result_t r;
		logic [SW-1:0] pick;
		logic [SW-1:0] d;
		logic [SW-1:0] last;
		logic [SW-1:0] owner;
		r = '0;
		if (op == OP_CREATE) begin
			if (live_n >= HANDLES) begin
				r.status = STS_FULL;
				r.live = live_n;
				return r;
			end
			d = live_n[SW-1:0];
			if (alloc_n > live_n && fl_head < HANDLES) begin
				pick = fl_head[SW-1:0];
				if (alloc_n - live_n == 7'd1)
					fl_head = CW'(HANDLES);
				else
					fl_head = {1'b0, hs_link[pick]};
			end else begin
				pick = alloc_n[SW-1:0];
				alloc_n = alloc_n + 7'd1;
				hs_gen[pick] = 16'd1;
			end
			hs_link[pick] = d;
			dn_owner[d] = pick;
			live_n = live_n + 7'd1;
			r = '{STS_OK, pick, hs_gen[pick], d, 6'd0, live_n};
		end else if (!slot_is_live(s, g)) begin
			r = '{STS_STALE, s, g, 6'd0, 6'd0, live_n};
		end else if (op == OP_DELETE) begin
			d = hs_link[s];
			last = SW'(live_n - 7'd1);
			owner = dn_owner[last];
			hs_link[owner] = d;
			dn_owner[d] = owner;
			hs_link[s] = (fl_head < HANDLES) ? fl_head[SW-1:0] : 6'd0;
			fl_head = {1'b0, s};
			hs_gen[s] = hs_gen[s] + 16'd1;
			live_n = live_n - 7'd1;
			r = '{STS_OK, s, g, d, last, live_n};
		end else begin
			r = '{STS_OK, s, g, hs_link[s], 6'd0, live_n};
		end
		return r;
	endfunction

	function automatic int draw_gap(int pct);
		int n;
		n = 0;
		while (n < 40 && $urandom_range(0, 99) < pct)
			n++;
		return n;
	endfunction

	task automatic send_word(logic [1:0] op, logic [SW-1:0] s, logic [GW-1:0] g, int gap,
			logic typed, table_result_t want);
		table_result_t pred;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		handle_slot <= s;
		handle_generation <= g;
		do @(posedge clk); while (busy);
		pred = predict_table_op(op, s, g);
		last_pred = pred;
		pending_results = {pending_results, typed ? want : pred};
		n_words++;
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic run_random(int count, int idle_pct);
		int create_pct;
		int r;
		int k;
		logic burst;
		logic [1:0] op;
		logic [SW-1:0] s;
		logic [GW-1:0] g;
		create_pct = 50;
		burst = 1'b0;
		for (int i = 0; i < count; i++) begin
			// shift the fill/drain balance every block of words
			if (i % 32 == 0) begin
				create_pct = $urandom_range(15, 75);
				burst = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			s = SW'($urandom);
			g = GW'($urandom);
			op = OP_CREATE;
			if (r >= create_pct) begin
				if (live_n != 0 && $urandom_range(0, 3) != 0) begin
					s = dn_owner[$urandom_range(0, live_n - 1)];
					g = hs_gen[s];
					k = $urandom_range(0, 9);
					op = (k < 5) ? OP_DELETE : (k < 9) ? OP_LOOKUP : OP_UNUSED;
				end else begin
					k = $urandom_range(0, 2);
					op = (k == 0) ? OP_DELETE : (k == 1) ? OP_LOOKUP : OP_UNUSED;
					if (alloc_n != 0 && $urandom_range(0, 1) == 1) begin
						s = SW'($urandom_range(0, alloc_n - 1));
						case ($urandom_range(0, 2))
							0: g = hs_gen[s];
							1: g = hs_gen[s] - 16'd1;
							default: g = hs_gen[s] + 16'd1;
						endcase
					end
				end
			end
			send_word(op, s, g, burst ? 0 : draw_gap(idle_pct), 1'b0, NO_RESULT);
		end
	endtask

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			if (fail_count < PRINT_LIMIT)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && done) begin
			n_results++;
			if (pending_results.size() == 0) begin
				if (fail_count < PRINT_LIMIT)
					$display("%0t: result with none expected, status %0d slot %0d", $time,
						status, out_slot);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", want.status, status);
				check_field("out_slot", want.slot, out_slot);
				check_field("out_generation", want.gen, out_generation);
				check_field("dense_slot", want.dense, dense_slot);
				check_field("moved_from", want.moved, moved_from);
				check_field("live_count", want.live, live_count);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no word moved for %0d cycles, %0d results outstanding", $time,
			STALL_LIMIT, pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		for (int i = 0; i < HANDLES; i++) begin
			hs_link[i] = '0;
			hs_gen[i] = '0;
			dn_owner[i] = '0;
		end
		fl_head = CW'(HANDLES);
		live_n = '0;
		alloc_n = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_word(directed_words[i].op, directed_words[i].slot, directed_words[i].gen,
				draw_gap(34), directed_words[i].typed, directed_words[i].want);

		// fill up, then push past full
		while (live_n < HANDLES)
			send_word(OP_CREATE, SW'($urandom), GW'($urandom), draw_gap(34), 1'b0, NO_RESULT);
		repeat (3)
			send_word(OP_CREATE, SW'($urandom), GW'($urandom), draw_gap(34), 1'b0, NO_RESULT);

		run_random(370, 34);
		drain_results();
		run_random(370, 83);
		drain_results();
		run_random(370, 0);
		drain_results();

		// churn one handle slot through create and delete
		if (live_n == HANDLES)
			send_word(OP_DELETE, dn_owner[0], hs_gen[dn_owner[0]], 0, 1'b0, NO_RESULT);
		for (int i = 0; i < CHURN_PAIRS; i++) begin
			send_word(OP_CREATE, SW'($urandom), GW'($urandom), 0, 1'b0, NO_RESULT);
			send_word(OP_DELETE, last_pred.slot, last_pred.gen, 0, 1'b0, NO_RESULT);
		end

		drain_results();
		repeat (8) @(posedge clk);

		$display("Ran %0d words, %0d results: creates, deletes, lookups, the unused code,",
			n_words, n_results);
		$display("full table, stale and freed handles, and back to back reuse of one slot.");
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
